>>> hw/rtl/twsd_pkg.sv
// ----------------------------------------------------------------------------
// twsd_pkg: shared types and constants
// Word widths, output limits, register codes and the CORDIC angle table for
// the tricycle steer and drive block.
// ----------------------------------------------------------------------------
package twsd_pkg;

  localparam int CORDIC_STAGES_DEF = 16;

  localparam int XW = 35;   // CORDIC x and y
  localparam int ZW = 19;   // angle accumulator, 2^-16 rad
  localparam int DW = 24;   // drive rate

  localparam logic signed [ZW-1:0] STEER_MAX = 19'sd25736;
  localparam logic signed [ZW-1:0] STEER_MIN = -19'sd25736;
  localparam logic signed [25:0]   DRIVE_MAX = 26'sd8388607;
  localparam logic signed [25:0]   DRIVE_MIN = -26'sd8388608;

  localparam logic REG_BASE_LEN   = 1'b0;
  localparam logic REG_INV_RADIUS = 1'b1;

  typedef struct packed {
    logic                   zero;
    logic signed [XW-1:0]   x;
    logic signed [XW-1:0]   y;
    logic signed [ZW-1:0]   z;
    logic signed [DW-1:0]   drive;
  } cell_word_t;

  // atan(2^-i) in 2^-16 rad, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_q16(input int idx);
    logic signed [ZW-1:0] a;
    case (idx)
      0:       a = 19'sd51472;
      1:       a = 19'sd30386;
      2:       a = 19'sd16055;
      3:       a = 19'sd8150;
      4:       a = 19'sd4091;
      5:       a = 19'sd2047;
      6:       a = 19'sd1024;
      7:       a = 19'sd512;
      8:       a = 19'sd256;
      9:       a = 19'sd128;
      10:      a = 19'sd64;
      11:      a = 19'sd32;
      12:      a = 19'sd16;
      13:      a = 19'sd8;
      14:      a = 19'sd4;
      15:      a = 19'sd2;
      16:      a = 19'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

>>> hw/rtl/twsd_front.sv
// ----------------------------------------------------------------------------
// twsd_front: operand preparation
// Two stages: the three products, then sign folding of the CORDIC operands
// and rounding and saturation of the drive rate.
// ----------------------------------------------------------------------------
module twsd_front
  import twsd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic signed [15:0]  linear_speed,
  input  logic signed [15:0]  yaw_rate,
  input  logic [15:0]         base_len_mm,
  input  logic [23:0]         inv_wheel_radius_q16,
  output logic                out_vld,
  output cell_word_t          out_word
);

  logic               a_vld;
  logic               a_neg;
  logic               a_zero;
  logic signed [26:0] a_px;
  logic signed [32:0] a_py;
  logic signed [40:0] a_pd;

  logic signed [XW-1:0] px_ext;
  logic signed [XW-1:0] py_ext;
  logic signed [41:0]   pd_rnd;
  logic signed [25:0]   pd_shr;
  logic signed [DW-1:0] drive_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    a_neg  <= linear_speed[15];
    a_zero <= (linear_speed == '0) || (yaw_rate == '0);
    a_px   <= 27'(linear_speed) * 27'sd1000;
    a_py   <= 33'($signed({1'b0, base_len_mm})) * 33'(yaw_rate);
    a_pd   <= 41'($signed({1'b0, inv_wheel_radius_q16})) * 41'(linear_speed);
  end

  always_comb begin
    px_ext = {{(XW-27){a_px[26]}}, a_px};
    py_ext = {{(XW-33){a_py[32]}}, a_py};
    pd_rnd = {a_pd[40], a_pd} + 42'sd32768;
    pd_shr = pd_rnd[41:16];
    if (pd_shr > DRIVE_MAX) begin
      drive_next = DRIVE_MAX[DW-1:0];
    end else if (pd_shr < DRIVE_MIN) begin
      drive_next = DRIVE_MIN[DW-1:0];
    end else begin
      drive_next = pd_shr[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_word.zero  <= a_zero;
    out_word.x     <= a_neg ? -px_ext : px_ext;
    out_word.y     <= a_neg ? -py_ext : py_ext;
    out_word.z     <= '0;
    out_word.drive <= drive_next;
  end

endmodule

>>> hw/rtl/twsd_cordic_cell.sv
// ----------------------------------------------------------------------------
// twsd_cordic_cell: one vectoring CORDIC iteration
// Rotates towards y = 0 by atan(2^-SHIFT) and hands the word on.
// ----------------------------------------------------------------------------
module twsd_cordic_cell
  import twsd_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       din_vld,
  input  cell_word_t din,
  output logic       dout_vld,
  output cell_word_t dout
);

  localparam logic signed [ZW-1:0] ANGLE = atan_q16(SHIFT);

  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  cell_word_t           word_next;

  always_comb begin
    dx        = din.y >>> SHIFT;
    dy        = din.x >>> SHIFT;
    word_next = din;
    if (!din.y[XW-1]) begin
      word_next.x = din.x + dx;
      word_next.y = din.y - dy;
      word_next.z = din.z + ANGLE;
    end else begin
      word_next.x = din.x - dx;
      word_next.y = din.y + dy;
      word_next.z = din.z - ANGLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout_vld <= 1'b0;
    end else begin
      dout_vld <= din_vld;
    end
  end

  always_ff @(posedge clk) begin
    dout <= word_next;
  end

endmodule

>>> hw/rtl/twist_to_steer_and_drive_top.sv
// ----------------------------------------------------------------------------
// twist_to_steer_and_drive_top: tricycle drive inverse kinematics
// Turns a velocity command into a steering angle and a drive wheel rate.
//
// A command word is taken on every clock edge where start is high; busy
// stays low, so a new word may follow in every cycle. Each command gives
// exactly one result on steer_angle and drive_rate, shown for one cycle
// with done high, after two stages of operand preparation, one CORDIC
// cell per iteration and one stage of angle rounding. Throughput is one
// word per cycle, set by the row of CORDIC cells.
// The user must write registers through cfg_write, cfg_index and cfg_data
// only while no command is in flight; the block does not enforce this.
// Index 0 is the wheel base in mm; index 1 the reciprocal wheel radius in Q8.16.
// Reset empties the pipeline (no done until new commands arrive) and loads
// the default wheel base and wheel radius. The receiver cannot stall:
// each result must be taken in the cycle it is shown.
// ----------------------------------------------------------------------------
module twist_to_steer_and_drive_top
  import twsd_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] linear_speed,
  input  logic signed [15:0] yaw_rate,
  output logic               done,
  output logic signed [15:0] steer_angle,
  output logic signed [23:0] drive_rate,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int LATENCY = CORDIC_STAGES + 3;

  logic [15:0] base_len_mm;
  logic [23:0] inv_wheel_radius_q16;

  logic       chain_vld  [0:CORDIC_STAGES];
  cell_word_t chain_word [0:CORDIC_STAGES];

  logic signed [ZW-1:0] z_rnd;
  logic signed [ZW-1:0] ang;
  logic signed [ZW-1:0] ang_next;
  cell_word_t           last_word;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_len_mm          <= 16'd1700;
      inv_wheel_radius_q16 <= 24'd546133;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_LEN:   base_len_mm          <= cfg_data[15:0];
        REG_INV_RADIUS: inv_wheel_radius_q16 <= cfg_data;
        default: ;
      endcase
    end
  end

  twsd_front u_front (
    .clk                  (clk),
    .rst                  (rst),
    .accept               (start & ~busy),
    .linear_speed         (linear_speed),
    .yaw_rate             (yaw_rate),
    .base_len_mm          (base_len_mm),
    .inv_wheel_radius_q16 (inv_wheel_radius_q16),
    .out_vld              (chain_vld[0]),
    .out_word             (chain_word[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    twsd_cordic_cell #(
      .SHIFT (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .din_vld  (chain_vld[k]),
      .din      (chain_word[k]),
      .dout_vld (chain_vld[k+1]),
      .dout     (chain_word[k+1])
    );
  end

  always_comb begin
    last_word = chain_word[CORDIC_STAGES];
    z_rnd     = last_word.z + 19'sd2;
    ang       = z_rnd >>> 2;
    if (last_word.zero) begin
      ang_next = '0;
    end else if (ang > STEER_MAX) begin
      ang_next = STEER_MAX;
    end else if (ang < STEER_MIN) begin
      ang_next = STEER_MIN;
    end else begin
      ang_next = ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    steer_angle <= ang_next[15:0];
    drive_rate  <= last_word.drive;
  end

  a_done_follows_start: assert property (
    @(posedge clk) disable iff (rst)
    start && !busy |-> ##LATENCY done
  ) else $error("command without result");

  a_steer_in_range: assert property (
    @(posedge clk) disable iff (rst)
    done |-> (steer_angle <= 16'sd25736) && (steer_angle >= -16'sd25736)
  ) else $error("steer angle out of range");

  a_zero_yaw_straight: assert property (
    @(posedge clk) disable iff (rst)
    start && !busy && (yaw_rate == '0) |-> ##LATENCY (steer_angle == '0)
  ) else $error("zero yaw rate gave a steering angle");

endmodule
